// ===== rtl/jst_pkg.sv =====
// Shared types and constants of the job slot table.
// No dependencies; jst_front, jst_queue, jst_back and the top import this package.
package jst_pkg;

	localparam int SLOTS    = 4096;
	localparam int IDX_W    = $clog2(SLOTS);
	localparam int FILL_W   = IDX_W + 1;
	localparam int GEN_W    = 8;
	localparam int CNT_W    = 24;
	localparam int CHUNK_W  = 16;
	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;
	localparam int QDEPTH   = 2;

	localparam logic [FILL_W-1:0] MIN_FREE_RESET = FILL_W'(1024);

	// Request function codes
	localparam logic [FUNC_W-1:0] FUNC_CREATE    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_TASK_DONE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY     = 2'd2;

	// Response status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_COUNT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_STALE     = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [CNT_W-1:0]   item_count;
		logic [CHUNK_W-1:0] items_per_task;
		logic [IDX_W-1:0]   handle_index;
		logic [GEN_W-1:0]   handle_generation;
	} req_word_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    job_index;
		logic [GEN_W-1:0]    job_generation;
		logic [CNT_W-1:0]    task_total;
		logic                finished;
		logic [FILL_W-1:0]   live_jobs;
	} rsp_word_t;

	// Classified command handed from the front to the back
	typedef enum logic [1:0] {
		CMD_CREATE,
		CMD_TASK_DONE,
		CMD_QUERY,
		CMD_REPLY
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [STATUS_W-1:0] status;
		logic [CNT_W-1:0]    total;
		logic [IDX_W-1:0]    index;
		logic [GEN_W-1:0]    generation;
	} cmd_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_ISSUE,
		B_POP_GEN,
		B_POP_WAIT,
		B_CHECK,
		B_REPLY
	} back_state_t;

endpackage

// ===== rtl/jst_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module jst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/jst_front.sv =====
// Front end: accepts request words, classifies them and computes the task
// count of a create by a restoring divider. Depends on jst_pkg.
module jst_front import jst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_word_t req,
	output logic      push,
	output cmd_t      push_cmd,
	input  logic      q_full
);

	localparam int STEP_W = $clog2(CNT_W + 1);

	front_state_t       state_q, state_d;
	cmd_t               cmd_q;
	logic [CNT_W-1:0]   quo_q;
	logic [CHUNK_W-1:0] rem_q;
	logic [CHUNK_W-1:0] divisor_q;
	logic [STEP_W-1:0]  step_q;

	logic               accept;
	logic               go_div;
	logic [CHUNK_W:0]   shifted;
	logic               take;
	logic [CHUNK_W-1:0] rem_next;

	assign req_ready = (state_q == F_IDLE);
	assign accept    = req_valid && req_ready;
	assign go_div    = (req.func == FUNC_CREATE) && (req.item_count != '0)
		&& (req.items_per_task != '0);

	// One quotient bit per cycle
	always_comb begin
		shifted  = {rem_q, quo_q[CNT_W-1]};
		take     = (shifted >= {1'b0, divisor_q});
		rem_next = take ? CHUNK_W'(shifted - {1'b0, divisor_q}) : shifted[CHUNK_W-1:0];
	end

	// Round the quotient up when a remainder is left
	always_comb begin
		push_cmd = cmd_q;
		if (cmd_q.kind == CMD_CREATE) begin
			push_cmd.total = quo_q + CNT_W'(rem_q != '0);
		end else begin
			push_cmd.total = '0;
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and queue push
	always_comb begin
		state_d = state_q;
		push    = 1'b0;
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					state_d = go_div ? F_DIV : F_PUSH;
				end
			end
			F_DIV: begin
				if (step_q == STEP_W'(CNT_W - 1)) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!q_full) begin
					push    = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	// Classify the accepted word and run the divider
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.total      <= '0;
			cmd_q.index      <= req.handle_index;
			cmd_q.generation <= req.handle_generation;
			quo_q            <= req.item_count;
			rem_q            <= '0;
			divisor_q        <= req.items_per_task;
			step_q           <= '0;
			case (req.func)
				FUNC_CREATE: begin
					cmd_q.kind   <= go_div ? CMD_CREATE : CMD_REPLY;
					cmd_q.status <= go_div ? ST_OK : ST_BAD_COUNT;
				end
				FUNC_TASK_DONE: begin
					cmd_q.kind   <= CMD_TASK_DONE;
					cmd_q.status <= ST_OK;
				end
				FUNC_QUERY: begin
					cmd_q.kind   <= CMD_QUERY;
					cmd_q.status <= ST_OK;
				end
				default: begin
					cmd_q.kind   <= CMD_REPLY;
					cmd_q.status <= ST_OK;
				end
			endcase
		end else if (state_q == F_DIV) begin
			quo_q  <= {quo_q[CNT_W-2:0], take};
			rem_q  <= rem_next;
			step_q <= step_q + 1'b1;
		end
	end

endmodule

// ===== rtl/jst_queue.sv =====
// Short command queue between the front and back ends.
// Depends on jst_pkg for the command type and depth.
module jst_queue import jst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic empty
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_QW = $clog2(QDEPTH + 1);

	cmd_t              entry_q [QDEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;

	assign full    = (count_q == CNT_QW'(QDEPTH));
	assign empty   = (count_q == '0);
	assign pop_cmd = entry_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== rtl/jst_back.sv =====
// Back end: executes classified commands against the generation, task
// count and free-index memories. Depends on jst_pkg and jst_ram.
module jst_back import jst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	output logic              pop,
	input  cmd_t              pop_cmd,
	input  logic              q_empty,
	input  logic [FILL_W-1:0] min_free,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rsp_word_t         rsp
);

	back_state_t       state_q, state_d;
	cmd_t              cur_q;
	rsp_word_t         res_q, res_d;
	rsp_word_t         rsp_q;
	rsp_word_t         rsp_load;
	logic              rsp_valid_q;
	logic [IDX_W-1:0]  slot_q;
	logic [IDX_W-1:0]  head_q;
	logic [IDX_W-1:0]  tail_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] next_fresh_q;
	logic [FILL_W-1:0] live_q;

	// Memory ports
	logic             gen_we, gen_re;
	logic [IDX_W-1:0] gen_waddr, gen_raddr;
	logic [GEN_W-1:0] gen_wdata, gen_rdata;
	logic             rem_we, rem_re;
	logic [IDX_W-1:0] rem_waddr, rem_raddr;
	logic [CNT_W-1:0] rem_wdata, rem_rdata;
	logic             fifo_we, fifo_re;
	logic [IDX_W-1:0] fifo_waddr, fifo_raddr;
	logic [IDX_W-1:0] fifo_wdata, fifo_rdata;

	// Events that move the counters
	logic ev_pop, ev_push, ev_fresh, ev_live_inc, ev_live_dec, ev_load;

	logic             reuse_now, fresh_ok, fifo_any;
	logic [GEN_W-1:0] gen_eff;

	jst_ram #(.WIDTH(GEN_W), .DEPTH(SLOTS)) u_gen_ram (
		.clk     (clk),
		.wr_en   (gen_we),
		.wr_addr (gen_waddr),
		.wr_data (gen_wdata),
		.rd_en   (gen_re),
		.rd_addr (gen_raddr),
		.rd_data (gen_rdata)
	);

	jst_ram #(.WIDTH(CNT_W), .DEPTH(SLOTS)) u_rem_ram (
		.clk     (clk),
		.wr_en   (rem_we),
		.wr_addr (rem_waddr),
		.wr_data (rem_wdata),
		.rd_en   (rem_re),
		.rd_addr (rem_raddr),
		.rd_data (rem_rdata)
	);

	jst_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_free_ram (
		.clk     (clk),
		.wr_en   (fifo_we),
		.wr_addr (fifo_waddr),
		.wr_data (fifo_wdata),
		.rd_en   (fifo_re),
		.rd_addr (fifo_raddr),
		.rd_data (fifo_rdata)
	);

	assign reuse_now = (fill_q > min_free);
	assign fresh_ok  = (next_fresh_q < FILL_W'(SLOTS));
	assign fifo_any  = (fill_q != '0);
	// Slots at or above the fresh mark were never handed out: generation zero
	assign gen_eff   = ({1'b0, cur_q.index} >= next_fresh_q) ? '0 : gen_rdata;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Next state, memory accesses and result fields
	always_comb begin
		state_d     = state_q;
		res_d       = res_q;
		pop         = 1'b0;
		gen_we      = 1'b0;
		gen_waddr   = cur_q.index;
		gen_wdata   = '0;
		gen_re      = 1'b0;
		gen_raddr   = cur_q.index;
		rem_we      = 1'b0;
		rem_waddr   = cur_q.index;
		rem_wdata   = cur_q.total;
		rem_re      = 1'b0;
		rem_raddr   = cur_q.index;
		fifo_we     = 1'b0;
		fifo_waddr  = tail_q;
		fifo_wdata  = cur_q.index;
		fifo_re     = 1'b0;
		fifo_raddr  = head_q;
		ev_pop      = 1'b0;
		ev_push     = 1'b0;
		ev_fresh    = 1'b0;
		ev_live_inc = 1'b0;
		ev_live_dec = 1'b0;
		ev_load     = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					pop          = 1'b1;
					res_d        = '0;
					res_d.status = pop_cmd.status;
					state_d      = B_ISSUE;
				end
			end
			B_ISSUE: begin
				case (cur_q.kind)
					CMD_CREATE: begin
						if (reuse_now || (!fresh_ok && fifo_any)) begin
							fifo_re = 1'b1;
							ev_pop  = 1'b1;
							state_d = B_POP_GEN;
						end else if (fresh_ok) begin
							// Fresh slot: stamp generation zero and load its count
							gen_we               = 1'b1;
							gen_waddr            = next_fresh_q[IDX_W-1:0];
							rem_we               = 1'b1;
							rem_waddr            = next_fresh_q[IDX_W-1:0];
							ev_fresh             = 1'b1;
							ev_live_inc          = 1'b1;
							res_d.job_index      = next_fresh_q[IDX_W-1:0];
							res_d.job_generation = '0;
							res_d.task_total     = cur_q.total;
							state_d              = B_REPLY;
						end else begin
							res_d.status = ST_FULL;
							state_d      = B_REPLY;
						end
					end
					CMD_TASK_DONE, CMD_QUERY: begin
						gen_re  = 1'b1;
						rem_re  = 1'b1;
						state_d = B_CHECK;
					end
					default: begin
						state_d = B_REPLY;
					end
				endcase
			end
			B_POP_GEN: begin
				gen_re    = 1'b1;
				gen_raddr = fifo_rdata;
				state_d   = B_POP_WAIT;
			end
			B_POP_WAIT: begin
				rem_we               = 1'b1;
				rem_waddr            = slot_q;
				ev_live_inc          = 1'b1;
				res_d.job_index      = slot_q;
				res_d.job_generation = gen_rdata;
				res_d.task_total     = cur_q.total;
				state_d              = B_REPLY;
			end
			B_CHECK: begin
				if (cur_q.kind == CMD_QUERY) begin
					res_d.finished = (gen_eff != cur_q.generation);
				end else if (gen_eff != cur_q.generation) begin
					res_d.status = ST_STALE;
				end else if (rem_rdata == '0) begin
					res_d.status = ST_BAD_COUNT;
				end else begin
					rem_we    = 1'b1;
					rem_wdata = rem_rdata - 1'b1;
					// Last task: retire the slot
					if (rem_rdata == CNT_W'(1)) begin
						gen_we         = 1'b1;
						gen_wdata      = gen_eff + 1'b1;
						res_d.finished = 1'b1;
						if (fill_q != FILL_W'(SLOTS)) begin
							fifo_we = 1'b1;
							ev_push = 1'b1;
						end
						if (live_q != '0) begin
							ev_live_dec = 1'b1;
						end
					end
				end
				state_d = B_REPLY;
			end
			B_REPLY: begin
				if (!rsp_valid_q || rsp_ready) begin
					ev_load = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// Stamp the live count onto the finished result
	always_comb begin
		rsp_load           = res_q;
		rsp_load.live_jobs = live_q;
	end

	// State, free queue pointers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			fill_q       <= '0;
			next_fresh_q <= '0;
			live_q       <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ev_pop) begin
				head_q <= (head_q == IDX_W'(SLOTS - 1)) ? '0 : head_q + 1'b1;
				fill_q <= fill_q - 1'b1;
			end
			if (ev_push) begin
				tail_q <= (tail_q == IDX_W'(SLOTS - 1)) ? '0 : tail_q + 1'b1;
				fill_q <= fill_q + 1'b1;
			end
			if (ev_fresh) begin
				next_fresh_q <= next_fresh_q + 1'b1;
			end
			if (ev_live_inc) begin
				live_q <= live_q + 1'b1;
			end else if (ev_live_dec) begin
				live_q <= live_q - 1'b1;
			end
			if (ev_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Hold the current command, result and output word
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_cmd;
		end
		res_q <= res_d;
		if (state_q == B_POP_GEN) begin
			slot_q <= fifo_rdata;
		end
		if (ev_load) begin
			rsp_q <= rsp_load;
		end
	end

`ifndef SYNTHESIS
	// Outside a pop in flight, every handed-out slot is live or waiting as free
	a_slot_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != B_POP_GEN && state_q != B_POP_WAIT)
		|-> (({1'b0, live_q} + {1'b0, fill_q}) == {1'b0, next_fresh_q}))
		else $error("live plus free count differs from allocated slots");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ev_pop |-> fifo_any)
		else $error("free queue popped while empty");

	a_full_real: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_load && res_q.status == ST_FULL) |-> (!fresh_ok && !fifo_any))
		else $error("table full reported while a slot was available");
`endif

endmodule

// ===== rtl/job_slot_table_with_generations.sv =====
// Job slot table with generation-tagged handles. Depends on jst_pkg,
// jst_front, jst_queue and jst_back. The front holds a create through its
// 24-step divider and takes no new word until it has pushed the previous one;
// the back takes each word through issue, then a free-queue read for a reused
// slot or a memory check for task done and query, then reply. Reset clears
// all control state; no clearing pass.
module job_slot_table_with_generations import jst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  req_word_t         req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rsp_word_t         rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [FILL_W-1:0] cfg_data
);

	logic [FILL_W-1:0] min_free_q;
	logic              q_push, q_full, q_pop, q_empty;
	cmd_t              q_push_cmd, q_pop_cmd;

	assign cfg_ready = 1'b1;

	// Reuse threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_free_q <= MIN_FREE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			min_free_q <= cfg_data;
		end
	end

	jst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.push      (q_push),
		.push_cmd  (q_push_cmd),
		.q_full    (q_full)
	);

	jst_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_cmd  (q_pop_cmd),
		.empty    (q_empty)
	);

	jst_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop       (q_pop),
		.pop_cmd   (q_pop_cmd),
		.q_empty   (q_empty),
		.min_free  (min_free_q),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
